FILE: sv/rlm_pkg.sv
// shared constants, types and register indexes of the rms level meter
package rlm_pkg;

    localparam int MAX_BLOCK_FRAMES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF      = 2;

    localparam int SAMPLE_W = 16;
    localparam int SQUARE_W = 31;
    localparam int LEVEL_W  = 16;
    localparam int BAR_W    = 8;
    localparam int PROD_W   = LEVEL_W + BAR_W;
    localparam int RAD_W    = 32;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SQRT_REM_W = LEVEL_W + 1;
    localparam int LEVEL_FRAC = 15;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [BAR_W-1:0] BAR_GAIN_RESET  = 8'd64;
    localparam logic [BAR_W-1:0] BAR_LIMIT_RESET = 8'd68;
    localparam logic [BAR_W-1:0] BAR_CLAMP_RESET = 8'd58;

    typedef enum logic [1:0] {
        REG_BAR_GAIN  = 2'd0,
        REG_BAR_LIMIT = 2'd1,
        REG_BAR_CLAMP = 2'd2
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SQRT = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DONE = 5'b10000
    } back_state_t;

    typedef struct packed {
        logic [BAR_W-1:0] gain;
        logic [BAR_W-1:0] limit;
        logic [BAR_W-1:0] clamp;
    } bar_cfg_t;

endpackage

FILE: sv/rlm_front.sv
// front end: takes frames, squares the sample and accumulates per block
module rlm_front #(
    parameter int MAX_BLOCK_FRAMES = rlm_pkg::MAX_BLOCK_FRAMES_DEF,
    parameter int CNT_W            = $clog2(MAX_BLOCK_FRAMES + 1),
    parameter int SUM_W            = 31 + $clog2(MAX_BLOCK_FRAMES)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic                               s_last_in_block,
    output logic                               push_valid,
    output logic [SUM_W+CNT_W-1:0]             push_data,
    input  logic                               queue_full
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_FRAMES);

    logic                           a_valid_reg, a_valid_next;
    logic [rlm_pkg::SQUARE_W-1:0]   square_reg;
    logic                           a_close_reg;
    logic [CNT_W-1:0]               a_cnt_reg;
    logic [CNT_W-1:0]               frame_cnt_reg, frame_cnt_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [CNT_W-1:0]               cnt_inc;
    logic                           close;
    logic                           accept;
    logic                           b_go;
    logic signed [2*rlm_pkg::SAMPLE_W-1:0] product;
    logic [SUM_W-1:0]               sum_add;

    assign product  = s_left_sample * s_left_sample;
    assign cnt_inc  = frame_cnt_reg + CNT_W'(1);
    assign close    = s_last_in_block || (cnt_inc == CNT_MAX);

    // accumulate stage stalls only when it closes a block and the queue is full
    assign b_go     = !(a_valid_reg && a_close_reg && queue_full);
    assign s_ready  = !a_valid_reg || b_go;
    assign accept   = s_valid && s_ready;

    assign sum_add    = sum_reg + SUM_W'(square_reg);
    assign push_valid = a_valid_reg && a_close_reg && !queue_full;
    assign push_data  = {sum_add, a_cnt_reg};

    always_comb begin
        frame_cnt_next = frame_cnt_reg;
        if (accept) begin
            frame_cnt_next = close ? '0 : cnt_inc;
        end
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (b_go) begin
            a_valid_next = 1'b0;
        end
        sum_next = sum_reg;
        if (a_valid_reg && b_go) begin
            sum_next = a_close_reg ? '0 : sum_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            frame_cnt_reg <= '0;
            sum_reg       <= '0;
        end else begin
            a_valid_reg   <= a_valid_next;
            frame_cnt_reg <= frame_cnt_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            square_reg  <= product[rlm_pkg::SQUARE_W-1:0];
            a_close_reg <= close;
            a_cnt_reg   <= cnt_inc;
        end
    end

endmodule

FILE: sv/rlm_queue.sv
// short fifo of closed blocks between front and back
module rlm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rlm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      fill_reg, fill_next;

    assign full      = (fill_reg == (AW+1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // pointers wrap at the depth, which need not be a power of two
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        fill_next = fill_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/rlm_back.sv
// back end: serial divide, serial square root, bar scaling and result register
module rlm_back #(
    parameter int CNT_W = $clog2(rlm_pkg::MAX_BLOCK_FRAMES_DEF + 1),
    parameter int SUM_W = rlm_pkg::SQUARE_W + $clog2(rlm_pkg::MAX_BLOCK_FRAMES_DEF)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  logic [SUM_W+CNT_W-1:0]            q_data,
    output logic                              q_pop,
    input  rlm_pkg::bar_cfg_t                 cfg,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rlm_pkg::LEVEL_W-1:0]       m_rms_level,
    output logic [rlm_pkg::BAR_W-1:0]         m_bar_length
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam int RW     = rlm_pkg::SQRT_REM_W;
    localparam int LW     = rlm_pkg::LEVEL_W;
    localparam int BW     = rlm_pkg::BAR_W;

    rlm_pkg::back_state_t state_reg, state_next;

    logic [STEP_W-1:0]          step_reg, step_next;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]           div_reg;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [rlm_pkg::RAD_W-1:0]  rad_reg, rad_next;
    logic [RW-1:0]              sq_rem_reg, sq_rem_next;
    logic [LW-1:0]              root_reg, root_next;
    logic [rlm_pkg::PROD_W-1:0] prod_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [LW-1:0]              level_out_reg;
    logic [BW-1:0]              bar_out_reg;

    logic [CNT_W:0]             div_trial;
    logic                       div_ge;
    logic [RW+1:0]              sq_shift;
    logic [RW+1:0]              sq_trial;
    logic                       sq_ge;
    logic [BW:0]                bar_raw;
    logic [BW-1:0]              bar_final;
    logic                       out_free;

    assign out_free = !m_valid_reg || m_ready;

    // restoring divider, one quotient bit a cycle
    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, div_reg});

    // digit-by-digit root, one result bit a cycle
    assign sq_shift  = {sq_rem_reg, rad_reg[rlm_pkg::RAD_W-1 -: 2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = (sq_shift >= sq_trial);

    assign bar_raw   = prod_reg[rlm_pkg::PROD_W-1:rlm_pkg::LEVEL_FRAC];
    assign bar_final = (bar_raw > {1'b0, cfg.limit}) ? cfg.clamp : bar_raw[BW-1:0];

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        rad_next     = rad_reg;
        sq_rem_next  = sq_rem_reg;
        root_next    = root_reg;
        q_pop        = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            rlm_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    quo_next   = q_data[SUM_W+CNT_W-1:CNT_W];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = rlm_pkg::ST_DIV;
                end
            end
            rlm_pkg::ST_DIV: begin
                quo_next  = {quo_reg[SUM_W-2:0], div_ge};
                rem_next  = div_ge ? CNT_W'(div_trial - {1'b0, div_reg}) : CNT_W'(div_trial);
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    // mean of squares never exceeds one in q2.30
                    rad_next    = rlm_pkg::RAD_W'(quo_next);
                    sq_rem_next = '0;
                    root_next   = '0;
                    step_next   = '0;
                    state_next  = rlm_pkg::ST_SQRT;
                end
            end
            rlm_pkg::ST_SQRT: begin
                sq_rem_next = sq_ge ? RW'(sq_shift - sq_trial) : RW'(sq_shift);
                root_next   = {root_reg[LW-2:0], sq_ge};
                rad_next    = {rad_reg[rlm_pkg::RAD_W-3:0], 2'b00};
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(rlm_pkg::SQRT_STEPS - 1)) begin
                    state_next = rlm_pkg::ST_MUL;
                end
            end
            rlm_pkg::ST_MUL: begin
                state_next = rlm_pkg::ST_DONE;
            end
            rlm_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = rlm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rlm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        rad_reg    <= rad_next;
        sq_rem_reg <= sq_rem_next;
        root_reg   <= root_next;
        if (q_pop) begin
            div_reg <= q_data[CNT_W-1:0];
        end
        if (state_reg == rlm_pkg::ST_MUL) begin
            prod_reg <= root_reg * cfg.gain;
        end
        if (state_reg == rlm_pkg::ST_DONE && out_free) begin
            level_out_reg <= root_reg;
            bar_out_reg   <= bar_final;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rms_level  = level_out_reg;
    assign m_bar_length = bar_out_reg;

endmodule

FILE: sv/block_rms_level_meter_core.sv
// top level of the rms level meter: apb registers, front, block queue and back
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_left_sample, s_last_in_block
//  m_        out        m_valid/m_ready    m_rms_level, m_bar_length
//  apb       in         psel/penable       paddr, pwdata, prdata
//
// one frame is taken per cycle while the block queue has room.
// each closed block goes through the bit-serial divider and the bit-serial square
// root in the back end, one block at a time; blocks that close faster than the
// back end finishes them fill the two-entry queue and then hold off s_ready.
// aresetn is synchronous; it clears the sum, frame count and queue and loads the registers with their reset values.
// a stalled m_ready holds the result while the front keeps accumulating.
module block_rms_level_meter_core #(
    parameter int MAX_BLOCK_FRAMES = rlm_pkg::MAX_BLOCK_FRAMES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [rlm_pkg::SAMPLE_W-1:0]  s_left_sample,
    input  logic                                 s_last_in_block,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rlm_pkg::LEVEL_W-1:0]          m_rms_level,
    output logic [rlm_pkg::BAR_W-1:0]            m_bar_length,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rlm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [rlm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [rlm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int CNT_W = $clog2(MAX_BLOCK_FRAMES + 1);
    localparam int SUM_W = 31 + $clog2(MAX_BLOCK_FRAMES);
    localparam int Q_W   = SUM_W + CNT_W;

    rlm_pkg::bar_cfg_t cfg_reg;
    logic              cfg_write;
    logic [1:0]        reg_sel;

    logic              push_valid;
    logic [Q_W-1:0]    push_data;
    logic              queue_full;
    logic              q_valid;
    logic [Q_W-1:0]    q_data;
    logic              q_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain  <= rlm_pkg::BAR_GAIN_RESET;
            cfg_reg.limit <= rlm_pkg::BAR_LIMIT_RESET;
            cfg_reg.clamp <= rlm_pkg::BAR_CLAMP_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                rlm_pkg::REG_BAR_GAIN:  cfg_reg.gain  <= pwdata[rlm_pkg::BAR_W-1:0];
                rlm_pkg::REG_BAR_LIMIT: cfg_reg.limit <= pwdata[rlm_pkg::BAR_W-1:0];
                rlm_pkg::REG_BAR_CLAMP: cfg_reg.clamp <= pwdata[rlm_pkg::BAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            rlm_pkg::REG_BAR_GAIN:  prdata = rlm_pkg::APB_DATA_W'(cfg_reg.gain);
            rlm_pkg::REG_BAR_LIMIT: prdata = rlm_pkg::APB_DATA_W'(cfg_reg.limit);
            rlm_pkg::REG_BAR_CLAMP: prdata = rlm_pkg::APB_DATA_W'(cfg_reg.clamp);
            default:                prdata = '0;
        endcase
    end

    rlm_front #(
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
        .CNT_W            (CNT_W),
        .SUM_W            (SUM_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_sample   (s_left_sample),
        .s_last_in_block (s_last_in_block),
        .push_valid      (push_valid),
        .push_data       (push_data),
        .queue_full      (queue_full)
    );

    rlm_queue #(
        .WIDTH (Q_W),
        .DEPTH (rlm_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    rlm_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .cfg          (cfg_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rms_level  (m_rms_level),
        .m_bar_length (m_bar_length)
    );

endmodule

FILE: sv/rlm_checker.sv
// port-level checks on the rms level meter, bound to the top level
module rlm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rlm_pkg::LEVEL_W-1:0] m_rms_level,
    input logic [rlm_pkg::BAR_W-1:0]   m_bar_length
);

    // a stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rms_level) && $stable(m_bar_length))
        else $error("result changed while stalled");

    // level is at most full scale
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rms_level <= 16'd32768)
        else $error("rms level above full scale");

    // silence gives an empty bar whatever the gain, limit and clamp
    a_silent_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rms_level == '0 |-> m_bar_length == '0)
        else $error("non-empty bar for a silent block");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind block_rms_level_meter_core rlm_checker u_rlm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_rms_level  (m_rms_level),
    .m_bar_length (m_bar_length)
);
